[rtl/core/fxa_pkg.sv]
package fxa_pkg;

    localparam int IN_WIDTH        = 56;
    localparam int CHAR_W          = 8;
    localparam int FD_W            = 3;
    localparam int APB_ADDR_W      = 3;
    localparam int APB_DATA_W      = 32;
    localparam int FRAC_BCD_DIGITS = 7;
    localparam int MUL_W           = 31;
    localparam int REM_W           = 11;
    localparam int DEF_INT_BITS    = 31;
    localparam int DEF_FRAC_BITS   = 24;

    localparam logic [REM_W:0]      ROUND_SCALE = 12'd2000;
    localparam logic [CHAR_W-1:0]   CHAR_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0]   CHAR_POINT  = 8'h2e;
    localparam logic [3:0]          DIGIT_NINE  = 4'd9;
    localparam logic [FD_W-1:0]     FD_RESET    = 3'd2;
    localparam logic [FD_W-1:0]     FD_MAX      = 3'd6;
    localparam logic [0:0]          REG_FRAC_DIGITS = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_PREP,
        ST_DIV,
        ST_START,
        ST_EMIT
    } fxa_state_t;

    typedef enum logic [1:0] {
        EM_IDLE,
        EM_INT,
        EM_POINT,
        EM_FRAC
    } fxa_emit_t;

    typedef struct packed {
        logic load;
        logic conv_step;
        logic div_load;
        logic div_step;
        logic emit_start;
    } fxa_ctrl_t;

    // decimal digits needed for the largest value of the given bit count
    function automatic int dec_digits(input int bits);
        longint unsigned top_val;
        longint unsigned p;
        int              n;
        top_val = (64'd1 << bits) - 64'd1;
        p       = 64'd1;
        n       = 0;
        while (p <= top_val)
        begin
            p = p * 64'd10;
            n = n + 1;
        end
        return n;
    endfunction

    // 2000 * 10^digits, the scale of the rounded fraction
    function automatic logic [MUL_W-1:0] round_mult(input logic [FD_W-1:0] dg);
        logic [MUL_W-1:0] m;
        case (dg)
            3'd0:    m = 31'd2000;
            3'd1:    m = 31'd20000;
            3'd2:    m = 31'd200000;
            3'd3:    m = 31'd2000000;
            3'd4:    m = 31'd20000000;
            3'd5:    m = 31'd200000000;
            default: m = 31'd2000000000;
        endcase
        return m;
    endfunction

endpackage

[rtl/core/fxa_in_if.sv]
interface fxa_in_if
    import fxa_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [IN_WIDTH-1:0] value_fixed;

    modport source (output valid, output value_fixed, input ready);
    modport sink   (input valid, input value_fixed, output ready);
endinterface

[rtl/core/fxa_out_if.sv]
interface fxa_out_if
    import fxa_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] out_char;
    logic              last_char;

    modport source (output valid, output out_char, output last_char, input ready);
    modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

[rtl/core/fxa_bin2bcd.sv]
module fxa_bin2bcd
    import fxa_pkg::*;
#(
    parameter int NDIG = FRAC_BCD_DIGITS
)
(
    input  logic              clk,
    input  logic              clr,
    input  logic              shift_en,
    input  logic              bit_in,
    output logic [4*NDIG-1:0] bcd
);

    logic [4*NDIG-1:0] bcd_reg;
    logic [4*NDIG-1:0] bcd_next;
    logic [4*NDIG-1:0] adj;

    // add three to every digit of five or more, then shift one bit in
    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ? bcd_reg[4*i +: 4] + 4'd3
                                                        : bcd_reg[4*i +: 4];
        end
        bcd_next = bcd_reg;
        if (clr)
        begin
            bcd_next = '0;
        end
        else if (shift_en)
        begin
            bcd_next = {adj[4*NDIG-2:0], bit_in};
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg <= bcd_next;
    end

    assign bcd = bcd_reg;

endmodule

[rtl/core/fxa_frac_unit.sv]
module fxa_frac_unit
    import fxa_pkg::*;
#(
    parameter int STEPS = DEF_INT_BITS
)
(
    input  logic             clk,
    input  fxa_ctrl_t        ctrl,
    input  logic [STEPS-1:0] frac_in,
    input  logic [MUL_W-1:0] mult_in,
    output logic             qbit
);

    logic [STEPS-1:0] fsr_reg, fsr_next;
    logic [MUL_W-1:0] m_reg, m_next;
    logic [MUL_W-1:0] hi_reg, hi_next;
    logic [MUL_W-1:0] ysr_reg, ysr_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [MUL_W:0]   sum;
    logic [REM_W:0]   trial;
    logic [REM_W:0]   diff;
    logic             ge;

    // lsb-first shift-add multiply keeps only the product bits above the point
    assign sum   = {1'b0, hi_reg} + (fsr_reg[0] ? {1'b0, m_reg} : {(MUL_W+1){1'b0}});
    // restoring division by the rounding scale, quotient msb first
    assign trial = {rem_reg, ysr_reg[MUL_W-1]};
    assign ge    = (trial >= ROUND_SCALE);
    assign diff  = trial - ROUND_SCALE;
    assign qbit  = ge;

    always_comb
    begin
        fsr_next = fsr_reg;
        m_next   = m_reg;
        hi_next  = hi_reg;
        ysr_next = ysr_reg;
        rem_next = rem_reg;
        if (ctrl.load)
        begin
            fsr_next = frac_in;
            m_next   = mult_in;
            hi_next  = '0;
        end
        else if (ctrl.conv_step)
        begin
            fsr_next = fsr_reg >> 1;
            hi_next  = sum[MUL_W:1];
        end
        if (ctrl.div_load)
        begin
            ysr_next = hi_reg + MUL_W'(1);
            rem_next = '0;
        end
        else if (ctrl.div_step)
        begin
            ysr_next = ysr_reg << 1;
            rem_next = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        fsr_reg <= fsr_next;
        m_reg   <= m_next;
        hi_reg  <= hi_next;
        ysr_reg <= ysr_next;
        rem_reg <= rem_next;
    end

endmodule

[rtl/core/fxa_emitter.sv]
module fxa_emitter
    import fxa_pkg::*;
#(
    parameter int NDI = 10
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  fxa_ctrl_t                    ctrl,
    input  logic [4*NDI-1:0]             int_bcd,
    input  logic [4*FRAC_BCD_DIGITS-1:0] frac_bcd,
    input  logic [FD_W-1:0]              dg,
    fxa_out_if.source                    out_ch,
    output logic                         done
);

    localparam int IDX_W = $clog2(NDI);

    fxa_emit_t         em_state_reg, em_state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [FD_W-1:0]   fidx_reg, fidx_next;
    logic              clamp_reg, clamp_next;
    logic              valid_reg, valid_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic              last_reg, last_next;

    logic              adv;
    logic              emit;
    logic [CHAR_W-1:0] char_d;
    logic              last_d;
    logic [IDX_W-1:0]  top_idx;
    logic [3:0]        frac_top;
    logic [3:0]        int_dig;
    logic [3:0]        frac_dig;

    assign adv = !valid_reg || out_ch.ready;

    // highest nonzero integer digit and the digit selects
    always_comb
    begin
        top_idx  = '0;
        int_dig  = '0;
        frac_top = '0;
        frac_dig = '0;
        for (int i = 0; i < NDI; i++)
        begin
            if (int_bcd[4*i +: 4] != 4'd0)
            begin
                top_idx = IDX_W'(i);
            end
            if (IDX_W'(i) == idx_reg)
            begin
                int_dig = int_bcd[4*i +: 4];
            end
        end
        for (int i = 0; i < FRAC_BCD_DIGITS; i++)
        begin
            if (FD_W'(i) == dg)
            begin
                frac_top = frac_bcd[4*i +: 4];
            end
            if (FD_W'(i) == fidx_reg)
            begin
                frac_dig = frac_bcd[4*i +: 4];
            end
        end
    end

    always_comb
    begin
        em_state_next = em_state_reg;
        case (em_state_reg)
            EM_IDLE:
            begin
                if (ctrl.emit_start)
                begin
                    em_state_next = EM_INT;
                end
            end
            EM_INT:
            begin
                if (adv && (idx_reg == '0))
                begin
                    em_state_next = (dg != '0) ? EM_POINT : EM_IDLE;
                end
            end
            EM_POINT:
            begin
                if (adv)
                begin
                    em_state_next = EM_FRAC;
                end
            end
            EM_FRAC:
            begin
                if (adv && (fidx_reg == '0))
                begin
                    em_state_next = EM_IDLE;
                end
            end
            default:
            begin
                em_state_next = EM_IDLE;
            end
        endcase
    end

    always_comb
    begin
        emit       = 1'b0;
        char_d     = CHAR_ZERO;
        last_d     = 1'b0;
        done       = 1'b0;
        idx_next   = idx_reg;
        fidx_next  = fidx_reg;
        clamp_next = clamp_reg;
        case (em_state_reg)
            EM_IDLE:
            begin
                if (ctrl.emit_start)
                begin
                    idx_next   = top_idx;
                    // rounded fraction reached the next power of ten
                    clamp_next = (frac_top != 4'd0);
                end
            end
            EM_INT:
            begin
                emit   = adv;
                char_d = CHAR_ZERO + {4'd0, int_dig};
                last_d = (idx_reg == '0) && (dg == '0);
                done   = adv && last_d;
                if (adv && (idx_reg != '0))
                begin
                    idx_next = idx_reg - IDX_W'(1);
                end
            end
            EM_POINT:
            begin
                emit   = adv;
                char_d = CHAR_POINT;
                if (adv)
                begin
                    fidx_next = dg - FD_W'(1);
                end
            end
            EM_FRAC:
            begin
                emit   = adv;
                char_d = CHAR_ZERO + {4'd0, (clamp_reg ? DIGIT_NINE : frac_dig)};
                last_d = (fidx_reg == '0);
                done   = adv && last_d;
                if (adv && (fidx_reg != '0))
                begin
                    fidx_next = fidx_reg - FD_W'(1);
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
        valid_next = emit ? 1'b1 : (out_ch.ready ? 1'b0 : valid_reg);
        char_next  = emit ? char_d : char_reg;
        last_next  = emit ? last_d : last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            em_state_reg <= EM_IDLE;
            valid_reg    <= 1'b0;
        end
        else
        begin
            em_state_reg <= em_state_next;
            valid_reg    <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        fidx_reg  <= fidx_next;
        clamp_reg <= clamp_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
    end

    assign out_ch.valid     = valid_reg;
    assign out_ch.out_char  = char_reg;
    assign out_ch.last_char = last_reg;

endmodule

[rtl/core/fixed_to_decimal_ascii_top.sv]
// sequence: the input beat starts the bit-serial integer/multiply pass, then the 31-step
//   divide by 2000, then one character beat per cycle while the sink is ready
// input: n characters (1..17) per number; a new input beat is taken only when idle, once
//   the last character of the previous number has been issued to the output register
// reset: asynchronous active-low rst_n idles the block, drops pending beats and sets
//   fraction_digits to 2
module fixed_to_decimal_ascii_top
    import fxa_pkg::*;
#(
    parameter int INT_BITS  = DEF_INT_BITS,
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    fxa_in_if.sink                in_ch,
    fxa_out_if.source             out_ch
);

    localparam int TOT     = INT_BITS + FRAC_BITS;
    localparam int STEPS   = (INT_BITS > FRAC_BITS) ? INT_BITS : FRAC_BITS;
    localparam int NDI     = dec_digits(INT_BITS);
    localparam int CNT_LIM = (STEPS > MUL_W) ? STEPS : MUL_W;
    localparam int CNT_W   = $clog2(CNT_LIM);

    fxa_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [FD_W-1:0]   fd_reg, fd_next;
    logic [FD_W-1:0]   dg_reg, dg_next;
    logic [STEPS-1:0]  isr_reg, isr_next;

    fxa_ctrl_t             ctrl;
    logic                  accept;
    logic                  cfg_wr;
    logic                  emit_done;
    logic                  qbit;
    logic [FD_W-1:0]       dg_load;
    logic [IN_WIDTH-1:0]   raw;
    logic [IN_WIDTH-1:0]   mag_full;
    logic                  sat;
    logic [TOT-1:0]        mag_tot;
    logic [INT_BITS-1:0]   ipart;
    logic [FRAC_BITS-1:0]  fpart;
    logic [STEPS-1:0]      frac_aligned;
    logic [4*NDI-1:0]      int_bcd;
    logic [4*FRAC_BCD_DIGITS-1:0] frac_bcd;

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_FRAC_DIGITS) ? APB_DATA_W'(fd_reg) : '0;

    always_comb
    begin
        fd_next = fd_reg;
        if (cfg_wr && (paddr[2] == REG_FRAC_DIGITS))
        begin
            fd_next = pwdata[FD_W-1:0];
        end
    end

    // magnitude with saturation, split at the binary point
    assign raw          = in_ch.value_fixed;
    assign mag_full     = raw[IN_WIDTH-1] ? (~raw + IN_WIDTH'(1)) : raw;
    assign sat          = ((mag_full >> TOT) != '0);
    assign mag_tot      = sat ? {TOT{1'b1}} : TOT'(mag_full);
    assign ipart        = mag_tot[TOT-1:FRAC_BITS];
    assign fpart        = mag_tot[FRAC_BITS-1:0];
    assign frac_aligned = STEPS'(fpart) << (STEPS - FRAC_BITS);
    assign dg_load      = (fd_reg > FD_MAX) ? FD_MAX : fd_reg;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (cnt_reg == CNT_W'(STEPS - 1))
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (cnt_reg == CNT_W'(MUL_W - 1))
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl     = '0;
        cnt_next = cnt_reg;
        dg_next  = dg_reg;
        isr_next = isr_reg;
        case (state_reg)
            ST_IDLE:
            begin
                ctrl.load = accept;
                cnt_next  = '0;
                if (accept)
                begin
                    dg_next  = dg_load;
                    isr_next = STEPS'(ipart);
                end
            end
            ST_CONV:
            begin
                ctrl.conv_step = 1'b1;
                isr_next       = isr_reg << 1;
                cnt_next       = (cnt_reg == CNT_W'(STEPS - 1)) ? '0 : cnt_reg + CNT_W'(1);
            end
            ST_PREP:
            begin
                ctrl.div_load = 1'b1;
            end
            ST_DIV:
            begin
                ctrl.div_step = 1'b1;
                cnt_next      = (cnt_reg == CNT_W'(MUL_W - 1)) ? '0 : cnt_reg + CNT_W'(1);
            end
            ST_START:
            begin
                ctrl.emit_start = 1'b1;
            end
            ST_EMIT:
            begin
                cnt_next = '0;
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            fd_reg    <= FD_RESET;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            fd_reg    <= fd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dg_reg  <= dg_next;
        isr_reg <= isr_next;
    end

    fxa_bin2bcd #(
        .NDIG (NDI)
    ) u_int_bcd (
        .clk      (clk),
        .clr      (ctrl.load),
        .shift_en (ctrl.conv_step),
        .bit_in   (isr_reg[STEPS-1]),
        .bcd      (int_bcd)
    );

    fxa_frac_unit #(
        .STEPS (STEPS)
    ) u_frac (
        .clk     (clk),
        .ctrl    (ctrl),
        .frac_in (frac_aligned),
        .mult_in (round_mult(dg_load)),
        .qbit    (qbit)
    );

    fxa_bin2bcd #(
        .NDIG (FRAC_BCD_DIGITS)
    ) u_frac_bcd (
        .clk      (clk),
        .clr      (ctrl.load),
        .shift_en (ctrl.div_step),
        .bit_in   (qbit),
        .bcd      (frac_bcd)
    );

    fxa_emitter #(
        .NDI (NDI)
    ) u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .int_bcd  (int_bcd),
        .frac_bcd (frac_bcd),
        .dg       (dg_reg),
        .out_ch   (out_ch),
        .done     (emit_done)
    );

endmodule
